/* rtl/core/imu_quaternion_frame_rotation_unit_defines.svh */
// Assertion helpers used by the checker file.
`ifndef IMU_QUATERNION_FRAME_ROTATION_UNIT_DEFINES_SVH
`define IMU_QUATERNION_FRAME_ROTATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IQFR_ASSERT_SAME(LABEL, ANTE, CONS) \
    LABEL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
        else $error("iqfr assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IQFR_ASSERT_NEXT(LABEL, ANTE, CONS) \
    LABEL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |=> (CONS)) \
        else $error("iqfr assertion failed");

`endif

/* rtl/core/iqfr_pkg.sv */
package iqfr_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_VECS  = 2;
    localparam int NUM_LANES = NUM_AXES * NUM_VECS;
    localparam int NUM_QUAT  = 4;

    // Load enables of the five pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } pipe_ctrl_t;

endpackage

/* rtl/core/iqfr_matrix.sv */
module iqfr_matrix #(
    parameter int FRAC_BITS    = 14,
    parameter int SAMPLE_WIDTH = 16,
    parameter int MW           = 34
) (
    input  logic                           clk,
    input  iqfr_pkg::pipe_ctrl_t           ctrl,
    input  logic signed [FRAC_BITS+1:0]    quat    [iqfr_pkg::NUM_QUAT],
    input  logic signed [SAMPLE_WIDTH-1:0] vec_in  [iqfr_pkg::NUM_LANES],
    output logic signed [MW-1:0]           mat     [iqfr_pkg::NUM_AXES*iqfr_pkg::NUM_AXES],
    output logic signed [SAMPLE_WIDTH-1:0] vec_out [iqfr_pkg::NUM_LANES]
);

    localparam int PW = 2 * (FRAC_BITS + 2);
    localparam logic signed [MW-1:0] ONE = {{(MW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    logic signed [FRAC_BITS+1:0] w, x, y, z;
    logic signed [PW-1:0] xx_next, yy_next, zz_next, xy_next, xz_next;
    logic signed [PW-1:0] yz_next, wx_next, wy_next, wz_next;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg;
    logic signed [PW-1:0] yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [MW-1:0] xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
    logic signed [MW-1:0] mat_next [iqfr_pkg::NUM_AXES*iqfr_pkg::NUM_AXES];
    logic signed [MW-1:0] mat_reg  [iqfr_pkg::NUM_AXES*iqfr_pkg::NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] vec1_reg [iqfr_pkg::NUM_LANES];
    logic signed [SAMPLE_WIDTH-1:0] vec2_reg [iqfr_pkg::NUM_LANES];

    assign w = quat[0];
    assign x = quat[1];
    assign y = quat[2];
    assign z = quat[3];

    // stage 1: quaternion products, exact
    assign xx_next = x * x;
    assign yy_next = y * y;
    assign zz_next = z * z;
    assign xy_next = x * y;
    assign xz_next = x * z;
    assign yz_next = y * z;
    assign wx_next = w * x;
    assign wy_next = w * y;
    assign wz_next = w * z;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            xx_reg   <= xx_next;
            yy_reg   <= yy_next;
            zz_reg   <= zz_next;
            xy_reg   <= xy_next;
            xz_reg   <= xz_next;
            yz_reg   <= yz_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            wz_reg   <= wz_next;
            vec1_reg <= vec_in;
        end
    end

    // stage 2: matrix entries
    assign xx_e = MW'(xx_reg);
    assign yy_e = MW'(yy_reg);
    assign zz_e = MW'(zz_reg);
    assign xy_e = MW'(xy_reg);
    assign xz_e = MW'(xz_reg);
    assign yz_e = MW'(yz_reg);
    assign wx_e = MW'(wx_reg);
    assign wy_e = MW'(wy_reg);
    assign wz_e = MW'(wz_reg);

    always_comb
    begin
        mat_next[0] = ONE - ((yy_e + zz_e) <<< 1);
        mat_next[1] = (xy_e - wz_e) <<< 1;
        mat_next[2] = (xz_e + wy_e) <<< 1;
        mat_next[3] = (xy_e + wz_e) <<< 1;
        mat_next[4] = ONE - ((xx_e + zz_e) <<< 1);
        mat_next[5] = (yz_e - wx_e) <<< 1;
        mat_next[6] = (xz_e - wy_e) <<< 1;
        mat_next[7] = (yz_e + wx_e) <<< 1;
        mat_next[8] = ONE - ((xx_e + yy_e) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            mat_reg  <= mat_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign mat     = mat_reg;
    assign vec_out = vec2_reg;

endmodule

/* rtl/core/iqfr_lane.sv */
module iqfr_lane #(
    parameter int MW           = 34,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_W        = 53
) (
    input  logic                           clk,
    input  iqfr_pkg::pipe_ctrl_t           ctrl,
    input  logic signed [MW-1:0]           row [iqfr_pkg::NUM_AXES],
    input  logic signed [SAMPLE_WIDTH-1:0] vec [iqfr_pkg::NUM_AXES],
    output logic signed [ACC_W-1:0]        acc
);

    logic signed [ACC_W-1:0] prod_next [iqfr_pkg::NUM_AXES];
    logic signed [ACC_W-1:0] prod_reg  [iqfr_pkg::NUM_AXES];
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;

    // products wrap at ACC_W bits when the accumulator is capped
    always_comb
    begin
        for (int j = 0; j < iqfr_pkg::NUM_AXES; j++)
        begin
            prod_next[j] = ACC_W'(row[j]) * ACC_W'(vec[j]);
        end
    end

    assign acc_next = prod_reg[0] + prod_reg[1] + prod_reg[2];

    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.ld4)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/core/iqfr_merge.sv */
module iqfr_merge #(
    parameter int FRAC_BITS    = 14,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_W        = 53
) (
    input  logic                           clk,
    input  iqfr_pkg::pipe_ctrl_t           ctrl,
    input  logic signed [ACC_W-1:0]        acc [iqfr_pkg::NUM_LANES],
    output logic signed [SAMPLE_WIDTH-1:0] res [iqfr_pkg::NUM_LANES]
);

    localparam int SH = 2 * FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [ACC_W-1:0]        rnd   [iqfr_pkg::NUM_LANES];
    logic signed [ACC_W-1:0]        shf   [iqfr_pkg::NUM_LANES];
    logic signed [SAMPLE_WIDTH-1:0] res_next [iqfr_pkg::NUM_LANES];
    logic signed [SAMPLE_WIDTH-1:0] res_reg  [iqfr_pkg::NUM_LANES];

    // round half up, then clamp to the sample range
    always_comb
    begin
        for (int k = 0; k < iqfr_pkg::NUM_LANES; k++)
        begin
            rnd[k] = acc[k] + HALF;
            shf[k] = rnd[k] >>> SH;
            if (shf[k] > SAT_HI)
            begin
                res_next[k] = SAT_HI[SAMPLE_WIDTH-1:0];
            end
            else if (shf[k] < SAT_LO)
            begin
                res_next[k] = SAT_LO[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                res_next[k] = shf[k][SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld5)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/imu_quaternion_frame_rotation_unit.sv */
// IMU quaternion frame rotation.
// Input channel (in_valid / in_stall): an orientation quaternion quat_w..quat_z
// (signed, FRAC_BITS fraction bits) plus one body-frame accel and rate vector.
// Output channel (out_valid / out_stall): the two vectors rotated to the world
// frame by the body-to-world matrix of the quaternion, rounded half up and
// clamped to the signed SAMPLE_WIDTH range. One result per transaction.
// Throughput: one transaction per cycle while out_stall is low, no state between transactions.
// Pipeline stages, in order from acceptance to out_valid: quaternion products,
// matrix, six lane multipliers, lane sums, round/clamp output register.
// A stalled output holds its payload; each stage keeps advancing into empty
// slots ahead of it, so in_stall rises only once the whole pipe is full,
// and in_stall follows out_stall combinationally.
// Reset clears all stage valids; the block takes input on the first cycle
// after reset is released.
module imu_quaternion_frame_rotation_unit #(
    parameter int FRAC_BITS    = 14,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [FRAC_BITS+1:0]    quat_w,
    input  logic signed [FRAC_BITS+1:0]    quat_x,
    input  logic signed [FRAC_BITS+1:0]    quat_y,
    input  logic signed [FRAC_BITS+1:0]    quat_z,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_body_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_body_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_body_z,
    input  logic signed [SAMPLE_WIDTH-1:0] rate_body_x,
    input  logic signed [SAMPLE_WIDTH-1:0] rate_body_y,
    input  logic signed [SAMPLE_WIDTH-1:0] rate_body_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] accel_world_x,
    output logic signed [SAMPLE_WIDTH-1:0] accel_world_y,
    output logic signed [SAMPLE_WIDTH-1:0] accel_world_z,
    output logic signed [SAMPLE_WIDTH-1:0] rate_world_x,
    output logic signed [SAMPLE_WIDTH-1:0] rate_world_y,
    output logic signed [SAMPLE_WIDTH-1:0] rate_world_z
);

    localparam int QW     = FRAC_BITS + 2;
    localparam int MW_RAW = 2 * QW + 2;
    localparam int MW     = (MW_RAW > 64) ? 64 : MW_RAW;
    localparam int AW_RAW = MW + SAMPLE_WIDTH + 3;
    localparam int ACC_W  = (AW_RAW > 64) ? 64 : AW_RAW;
    localparam int NA     = iqfr_pkg::NUM_AXES;

    iqfr_pkg::pipe_ctrl_t ctrl;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;

    logic signed [QW-1:0]           quat     [iqfr_pkg::NUM_QUAT];
    logic signed [SAMPLE_WIDTH-1:0] vec_in   [iqfr_pkg::NUM_LANES];
    logic signed [SAMPLE_WIDTH-1:0] vec_mat  [iqfr_pkg::NUM_LANES];
    logic signed [MW-1:0]           mat      [NA*NA];
    logic signed [MW-1:0]           lane_row [iqfr_pkg::NUM_LANES][NA];
    logic signed [SAMPLE_WIDTH-1:0] lane_vec [iqfr_pkg::NUM_LANES][NA];
    logic signed [ACC_W-1:0]        lane_acc [iqfr_pkg::NUM_LANES];
    logic signed [SAMPLE_WIDTH-1:0] res      [iqfr_pkg::NUM_LANES];

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        ctrl.ld5 = !v5_reg || !out_stall;
        ctrl.ld4 = !v4_reg || ctrl.ld5;
        ctrl.ld3 = !v3_reg || ctrl.ld4;
        ctrl.ld2 = !v2_reg || ctrl.ld3;
        ctrl.ld1 = !v1_reg || ctrl.ld2;
        v1_next  = ctrl.ld1 ? in_valid : v1_reg;
        v2_next  = ctrl.ld2 ? v1_reg : v2_reg;
        v3_next  = ctrl.ld3 ? v2_reg : v3_reg;
        v4_next  = ctrl.ld4 ? v3_reg : v4_reg;
        v5_next  = ctrl.ld5 ? v4_reg : v5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    assign in_stall  = !ctrl.ld1;
    assign out_valid = v5_reg;

    assign quat[0]   = quat_w;
    assign quat[1]   = quat_x;
    assign quat[2]   = quat_y;
    assign quat[3]   = quat_z;
    assign vec_in[0] = accel_body_x;
    assign vec_in[1] = accel_body_y;
    assign vec_in[2] = accel_body_z;
    assign vec_in[3] = rate_body_x;
    assign vec_in[4] = rate_body_y;
    assign vec_in[5] = rate_body_z;

    iqfr_matrix #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MW           (MW)
    ) u_matrix (
        .clk     (clk),
        .ctrl    (ctrl),
        .quat    (quat),
        .vec_in  (vec_in),
        .mat     (mat),
        .vec_out (vec_mat)
    );

    // lane k: matrix row k%3 applied to vector k/3
    for (genvar k = 0; k < iqfr_pkg::NUM_LANES; k++)
    begin : g_lane
        for (genvar j = 0; j < NA; j++)
        begin : g_tap
            assign lane_row[k][j] = mat[(k % NA) * NA + j];
            assign lane_vec[k][j] = vec_mat[(k / NA) * NA + j];
        end

        iqfr_lane #(
            .MW           (MW),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACC_W        (ACC_W)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .row  (lane_row[k]),
            .vec  (lane_vec[k]),
            .acc  (lane_acc[k])
        );
    end

    iqfr_merge #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_W        (ACC_W)
    ) u_merge (
        .clk  (clk),
        .ctrl (ctrl),
        .acc  (lane_acc),
        .res  (res)
    );

    assign accel_world_x = res[0];
    assign accel_world_y = res[1];
    assign accel_world_z = res[2];
    assign rate_world_x  = res[3];
    assign rate_world_y  = res[4];
    assign rate_world_z  = res[5];

endmodule

/* rtl/core/iqfr_checker.sv */
`include "imu_quaternion_frame_rotation_unit_defines.svh"

module iqfr_checker #(
    parameter int FRAC_BITS    = 14,
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic signed [FRAC_BITS+1:0]    quat_w,
    input logic signed [FRAC_BITS+1:0]    quat_x,
    input logic signed [FRAC_BITS+1:0]    quat_y,
    input logic signed [FRAC_BITS+1:0]    quat_z,
    input logic signed [SAMPLE_WIDTH-1:0] accel_body_x,
    input logic signed [SAMPLE_WIDTH-1:0] accel_body_y,
    input logic signed [SAMPLE_WIDTH-1:0] accel_body_z,
    input logic signed [SAMPLE_WIDTH-1:0] rate_body_x,
    input logic signed [SAMPLE_WIDTH-1:0] rate_body_y,
    input logic signed [SAMPLE_WIDTH-1:0] rate_body_z,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] accel_world_x,
    input logic signed [SAMPLE_WIDTH-1:0] accel_world_y,
    input logic signed [SAMPLE_WIDTH-1:0] accel_world_z,
    input logic signed [SAMPLE_WIDTH-1:0] rate_world_x,
    input logic signed [SAMPLE_WIDTH-1:0] rate_world_y,
    input logic signed [SAMPLE_WIDTH-1:0] rate_world_z
);

    localparam int IN_W  = iqfr_pkg::NUM_QUAT * (FRAC_BITS + 2)
                         + iqfr_pkg::NUM_LANES * SAMPLE_WIDTH;
    localparam int OUT_W = iqfr_pkg::NUM_LANES * SAMPLE_WIDTH;

    logic             in_fire;
    logic [IN_W-1:0]  in_bits;
    logic [OUT_W-1:0] out_bits;

    assign in_fire  = in_valid && !in_stall;
    assign in_bits  = {quat_w, quat_x, quat_y, quat_z,
                       accel_body_x, accel_body_y, accel_body_z,
                       rate_body_x, rate_body_y, rate_body_z};
    assign out_bits = {accel_world_x, accel_world_y, accel_world_z,
                       rate_world_x, rate_world_y, rate_world_z};

    // a held result keeps its payload
    `IQFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bits))

    // a stalled input transaction stays offered unchanged
    `IQFR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_bits))

    // with nothing waiting at the output the pipe can always take input
    `IQFR_ASSERT_SAME(a_empty_takes, !out_valid, !in_stall)

    // an accepted transaction reaches out_valid when the output is not held back
    `IQFR_ASSERT_NEXT(a_latency, in_fire ##1 (!out_stall) [*4], out_valid)

endmodule

bind imu_quaternion_frame_rotation_unit iqfr_checker #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iqfr_checker (.*);
